// File: design/mrrw_pkg.sv
// Package for the round-robin mutex core: field widths, command and status
// codes, and the item structs shared by the channels and the datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package mrrw_pkg;

   localparam int CMD_W     = 2;
   localparam int TASK_ID_W = 5;
   localparam int BLOCKED_W = 32;
   localparam int STATUS_W  = 3;

   // Command codes; the fourth code is unused and answers busy.
   localparam logic [CMD_W-1:0] CMD_TRY_LOCK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOCK     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UNLOCK   = 2'd2;

   // Status codes returned with every result item.
   localparam logic [STATUS_W-1:0] ST_ACQUIRED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BUSY       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_QUEUED     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_RECURSIVE  = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOT_LOCKED = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NOT_OWNER  = 3'd6;

   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [TASK_ID_W-1:0] task_id;
      logic [BLOCKED_W-1:0] blocked_tasks;
   } item_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic                 wake_valid;
      logic [TASK_ID_W-1:0] wake_task;
   } result_type;

endpackage

// File: design/mrrw_ifs.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on mrrw_pkg for the field widths.
`timescale 1ns / 1ps

interface mrrw_req_if import mrrw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CMD_W-1:0]     command;
   logic [TASK_ID_W-1:0] task_id;
   logic [BLOCKED_W-1:0] blocked_tasks;

   modport source (output valid, command, task_id, blocked_tasks, input ready);
   modport sink   (input valid, command, task_id, blocked_tasks, output ready);
endinterface

interface mrrw_rsp_if import mrrw_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic                 wake_valid;
   logic [TASK_ID_W-1:0] wake_task;

   modport source (output valid, status, wake_valid, wake_task, input ready);
   modport sink   (input valid, status, wake_valid, wake_task, output ready);
endinterface

// File: design/mrrw_wake_scan.sv
// Rotating priority encoder that picks the next waiter to wake on unlock
// and works out which waiter bits the scan passes over. Uses mrrw_pkg.
`timescale 1ns / 1ps

module mrrw_wake_scan import mrrw_pkg::*; #(
   parameter int TASKS = 32
) (
   input  logic [TASKS-1:0]     waiters,
   input  logic [TASKS-1:0]     candidates,
   input  logic [TASK_ID_W-1:0] start,
   output logic                 found,
   output logic [TASK_ID_W-1:0] wake_task,
   output logic [TASKS-1:0]     wake_onehot,
   output logic [TASKS-1:0]     waiters_next
);

   logic [TASKS:0]   above_bit;
   logic [TASKS:0]   le_full;
   logic [TASKS-1:0] gt_mask;
   logic [TASKS-1:0] hi_cand;
   logic [TASKS-1:0] pick;
   logic [TASKS-1:0] upto;
   logic [TASKS-1:0] clear;

   // Bits strictly above the start position come first in the rotation.
   assign above_bit = (TASKS+1)'(2) << start;
   assign le_full   = above_bit - (TASKS+1)'(1);
   assign gt_mask   = ~le_full[TASKS-1:0];

   assign hi_cand     = candidates & gt_mask;
   assign found       = |candidates;
   assign pick        = (|hi_cand) ? hi_cand : candidates;
   assign wake_onehot = pick & (~pick + TASKS'(1));
   assign upto        = wake_onehot | (wake_onehot - TASKS'(1));

   // Passed bits: from just above the start up to the winner, wrapping if needed.
   // With no winner every waiter bit is passed and dropped.
   always_comb begin
      if (|hi_cand) begin
         clear = gt_mask & upto;
      end else if (found) begin
         clear = gt_mask | upto;
      end else begin
         clear = '1;
      end
   end

   assign waiters_next = waiters & ~clear;

   always_comb begin
      wake_task = '0;
      for (int i = 0; i < TASKS; i++) begin
         if (wake_onehot[i]) begin
            wake_task = wake_task | TASK_ID_W'(i);
         end
      end
   end

endmodule

// File: design/mrrw_lock_ctrl.sv
// Mutex state (locked flag, owner, waiter bitmap) and the command decode
// that turns one item into one result. Uses mrrw_pkg and mrrw_wake_scan.
`timescale 1ns / 1ps

module mrrw_lock_ctrl import mrrw_pkg::*; #(
   parameter int TASKS = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   output result_type result
);

   logic                 locked_ff,  locked_in;
   logic [TASK_ID_W-1:0] owner_ff,   owner_in;
   logic [TASKS-1:0]     waiters_ff, waiters_in;

   logic                 valid_id;
   logic [TASKS-1:0]     tid_onehot;
   logic [TASKS-1:0]     candidates;
   logic                 scan_found;
   logic [TASK_ID_W-1:0] scan_task;
   logic [TASKS-1:0]     scan_onehot;
   logic [TASKS-1:0]     scan_waiters;

   assign valid_id   = int'(item.task_id) < TASKS;
   assign tid_onehot = {{(TASKS-1){1'b0}}, 1'b1} << item.task_id;
   assign candidates = waiters_ff & item.blocked_tasks[TASKS-1:0];

   mrrw_wake_scan #(.TASKS(TASKS)) u_scan (
      .waiters      (waiters_ff),
      .candidates   (candidates),
      .start        (item.task_id),
      .found        (scan_found),
      .wake_task    (scan_task),
      .wake_onehot  (scan_onehot),
      .waiters_next (scan_waiters)
   );

   always_comb begin
      locked_in         = locked_ff;
      owner_in          = owner_ff;
      waiters_in        = waiters_ff;
      result.status     = ST_BUSY;
      result.wake_valid = 1'b0;
      result.wake_task  = '0;
      case (item.command)
         CMD_TRY_LOCK, CMD_LOCK: begin
            if (!valid_id) begin
               result.status = ST_BUSY;
            end else if (!locked_ff) begin
               locked_in     = 1'b1;
               owner_in      = item.task_id;
               result.status = ST_ACQUIRED;
            end else if (owner_ff == item.task_id) begin
               result.status = ST_RECURSIVE;
            end else if (item.command == CMD_LOCK) begin
               waiters_in    = waiters_ff | tid_onehot;
               result.status = ST_QUEUED;
            end else begin
               result.status = ST_BUSY;
            end
         end
         CMD_UNLOCK: begin
            if (!valid_id) begin
               result.status = ST_NOT_OWNER;
            end else if (!locked_ff) begin
               result.status = ST_NOT_LOCKED;
            end else if (owner_ff != item.task_id) begin
               result.status = ST_NOT_OWNER;
            end else begin
               locked_in         = 1'b0;
               owner_in          = '0;
               waiters_in        = scan_waiters;
               result.status     = ST_RELEASED;
               result.wake_valid = scan_found;
               result.wake_task  = scan_found ? scan_task : '0;
            end
         end
         default: begin
            result.status = ST_BUSY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         locked_ff  <= 1'b0;
         owner_ff   <= '0;
         waiters_ff <= '0;
      end else if (step) begin
         locked_ff  <= locked_in;
         owner_ff   <= owner_in;
         waiters_ff <= waiters_in;
      end
   end

`ifndef SYNTHESIS
   a_wake_only_on_release: assert property (@(posedge clock) disable iff (reset)
      step && result.wake_valid |-> result.status == ST_RELEASED)
      else $error("wake reported without a release");

   a_release_frees: assert property (@(posedge clock) disable iff (reset)
      step && result.status == ST_RELEASED |=> !locked_ff)
      else $error("mutex still locked after release");

   a_woken_bit_cleared: assert property (@(posedge clock) disable iff (reset)
      step && result.wake_valid |=> (waiters_ff & $past(scan_onehot)) == '0)
      else $error("woken task still in waiter bitmap");

   a_acquire_sets_owner: assert property (@(posedge clock) disable iff (reset)
      step && result.status == ST_ACQUIRED |=> locked_ff && owner_ff == $past(item.task_id))
      else $error("acquire did not record the owner");
`endif

endmodule

// File: design/mutex_with_round_robin_wake_core.sv
// Top level of the round-robin mutex core: request and response channels,
// input and result registers. Uses mrrw_pkg, mrrw_ifs and mrrw_lock_ctrl.
`timescale 1ns / 1ps

// Hardware mutex for up to TASKS tasks. Each request item carries a command
// (try-lock, blocking lock, unlock), the calling task and a bitmap of the
// tasks that are currently blocked; each request yields exactly one response
// item with a status code and, on a successful unlock, the task that was
// woken. An unlock scans the waiter bitmap round-robin starting after the
// caller, drops stale waiter bits it passes and wakes the first waiter that
// is still blocked. A response goes valid when its item moves from the input
// register into the result register, and it sits in the result register
// until the response handshake. A new item is accepted every cycle unless
// a stalled consumer holds the result register while the input register is
// full: the rotating priority encoder and the state update settle
// combinationally between those two registers.
// The response register lets the next request be taken while a response
// waits on a stalled consumer.
module mutex_with_round_robin_wake_core import mrrw_pkg::*; #(
   parameter int TASKS = 32
) (
   input  logic   clock,
   input  logic   reset,
   mrrw_req_if.sink   req_chan,
   mrrw_rsp_if.source rsp_chan
);

   item_type   in_ff;
   logic       in_valid_ff, in_valid_in;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type result;
   logic       advance;
   logic       step;
   logic       req_fire;

   // The result register can take a new value when it is empty or being read.
   assign advance  = !rsp_valid_ff || rsp_chan.ready;
   assign step     = in_valid_ff && advance;
   assign req_fire = req_chan.valid && req_chan.ready;

   // The input register frees up in the same cycle its item moves on.
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end

      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_ff.command       <= req_chan.command;
         in_ff.task_id       <= req_chan.task_id;
         in_ff.blocked_tasks <= req_chan.blocked_tasks;
      end
      if (step) begin
         rsp_ff <= result;
      end
   end

   // The mutex state advances exactly when an item leaves the input register.
   mrrw_lock_ctrl #(.TASKS(TASKS)) u_lock (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (in_ff),
      .result (result)
   );

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_ff.status;
   assign rsp_chan.wake_valid = rsp_ff.wake_valid;
   assign rsp_chan.wake_task  = rsp_ff.wake_task;

endmodule
